### rtl/core/suart_pkg.sv
// suart_pkg: shared types and constants for the tick-driven 8N1 UART.
// Used by soft_uart_rx_tx and its port checker; no dependencies.
package suart_pkg;

  localparam int unsigned IN_W  = 16;
  localparam int unsigned OUT_W = 16;

  localparam logic [7:0] BIT_TICKS_RST = 8'd1;
  localparam logic [7:0] RX_HOLD_RST   = 8'd24;
  localparam logic [7:0] ELAPSED_MAX   = 8'hFF;
  localparam logic [3:0] NUM_BITS      = 4'd8;
  localparam logic [3:0] LAST_BIT      = 4'd7;

  typedef enum logic [1:0] {
    CFG_ENABLE    = 2'd0,
    CFG_BIT_TICKS = 2'd1,
    CFG_RX_HOLD   = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    RX_IDLE = 2'd0,
    RX_DATA = 2'd1,
    RX_HOLD = 2'd2
  } rx_phase_t;

  typedef enum logic [1:0] {
    TX_IDLE  = 2'd0,
    TX_START = 2'd1,
    TX_DATA  = 2'd2,
    TX_STOP  = 2'd3
  } tx_phase_t;

endpackage

### rtl/core/soft_uart_rx_tx.sv
// soft_uart_rx_tx: tick-driven 8N1 serial receiver and transmitter.
// The result item is registered when its tick item is taken.
// Throughput: one tick item per cycle; a held result stalls input only when
// the output register is full and not taken.
// Reset (rst, synchronous): both sides idle, line high, enable 0,
// bit_ticks 1, rx_hold_ticks 24. Depends on suart_pkg.
module soft_uart_rx_tx
  import suart_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              s_tvalid,
  output logic              s_tready,
  // rx_line[0], send_request[1], send_byte[9:2], host_ready[10], zero[15:11]
  input  logic [IN_W-1:0]   s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // tx_line[0], tx_idle[1], rx_valid[2], rx_byte[10:3], zero[15:11]
  output logic [OUT_W-1:0]  m_tdata
);

  logic       enable;
  logic [7:0] bit_ticks;
  logic [7:0] rx_hold_ticks;

  rx_phase_t  rx_phase, rx_phase_next;
  logic [7:0] rx_elapsed, rx_elapsed_next;
  logic [7:0] rx_shift, rx_shift_next;
  logic [3:0] rx_bits, rx_bits_next;
  tx_phase_t  tx_phase, tx_phase_next;
  logic [7:0] tx_elapsed, tx_elapsed_next;
  logic [7:0] tx_data, tx_data_next;
  logic [3:0] tx_bits, tx_bits_next;
  logic       tx_level, tx_level_next;

  logic       rx_valid_next;
  logic [7:0] rx_byte_next;
  logic [OUT_W-1:0] out_data;

  logic       in_line, in_req, in_ready;
  logic [7:0] in_byte;
  logic       take;

  assign in_line  = s_tdata[0];
  assign in_req   = s_tdata[1];
  assign in_byte  = s_tdata[9:2];
  assign in_ready = s_tdata[10];

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign take      = s_tvalid && s_tready;
  assign m_tdata   = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      bit_ticks     <= BIT_TICKS_RST;
      rx_hold_ticks <= RX_HOLD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ENABLE:    enable        <= cfg_data[0];
        CFG_BIT_TICKS: bit_ticks     <= cfg_data;
        CFG_RX_HOLD:   rx_hold_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    rx_phase_next   = rx_phase;
    rx_elapsed_next = (rx_elapsed == ELAPSED_MAX) ? rx_elapsed : rx_elapsed + 8'd1;
    rx_shift_next   = rx_shift;
    rx_bits_next    = rx_bits;
    tx_phase_next   = tx_phase;
    tx_elapsed_next = (tx_elapsed == ELAPSED_MAX) ? tx_elapsed : tx_elapsed + 8'd1;
    tx_data_next    = tx_data;
    tx_bits_next    = tx_bits;
    tx_level_next   = tx_level;
    rx_valid_next   = 1'b0;
    rx_byte_next    = 8'd0;

    if (in_req && enable) begin
      tx_phase_next   = TX_START;
      tx_data_next    = in_byte;
      tx_elapsed_next = 8'd0;
    end

    unique case (rx_phase)
      RX_IDLE: begin
        if (!in_line) begin
          rx_elapsed_next = 8'd0;
          rx_shift_next   = 8'd0;
          rx_bits_next    = 4'd0;
          rx_phase_next   = RX_DATA;
        end
      end
      RX_DATA: begin
        if (rx_elapsed_next >= bit_ticks) begin
          rx_shift_next   = {in_line, rx_shift[7:1]};
          rx_elapsed_next = 8'd0;
          rx_bits_next    = rx_bits + 4'd1;
          if (rx_bits_next >= NUM_BITS) begin
            rx_phase_next = RX_HOLD;
          end
        end
      end
      RX_HOLD: begin
        if (rx_elapsed_next >= rx_hold_ticks) begin
          if (enable && in_ready) begin
            rx_valid_next = 1'b1;
            rx_byte_next  = rx_shift;
          end
          rx_phase_next = RX_IDLE;
        end
      end
      default: rx_phase_next = RX_IDLE;
    endcase

    unique case (tx_phase_next)
      TX_IDLE: begin
        tx_level_next = 1'b1;
        tx_bits_next  = 4'd0;
      end
      TX_START: begin
        if (tx_elapsed_next >= bit_ticks) begin
          tx_phase_next   = TX_DATA;
          tx_level_next   = 1'b0;
          tx_elapsed_next = 8'd0;
        end
      end
      TX_DATA: begin
        if (tx_elapsed_next >= bit_ticks) begin
          if (tx_bits > LAST_BIT) begin
            tx_phase_next = TX_STOP;
          end else begin
            tx_elapsed_next = 8'd0;
            tx_level_next   = tx_data_next[tx_bits[2:0]];
            tx_bits_next    = tx_bits + 4'd1;
          end
        end
      end
      TX_STOP: begin
        tx_elapsed_next = 8'd0;
        tx_level_next   = 1'b1;
        tx_phase_next   = TX_IDLE;
        tx_bits_next    = 4'd0;
      end
      default: tx_phase_next = TX_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase   <= RX_IDLE;
      rx_elapsed <= 8'd0;
      rx_shift   <= 8'd0;
      rx_bits    <= 4'd0;
      tx_phase   <= TX_IDLE;
      tx_elapsed <= 8'd0;
      tx_data    <= 8'd0;
      tx_bits    <= 4'd0;
      tx_level   <= 1'b1;
    end else if (take) begin
      rx_phase   <= rx_phase_next;
      rx_elapsed <= rx_elapsed_next;
      rx_shift   <= rx_shift_next;
      rx_bits    <= rx_bits_next;
      tx_phase   <= tx_phase_next;
      tx_elapsed <= tx_elapsed_next;
      tx_data    <= tx_data_next;
      tx_bits    <= tx_bits_next;
      tx_level   <= tx_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= {5'd0, rx_byte_next, rx_valid_next,
                   (tx_phase_next == TX_IDLE), tx_level_next};
    end
  end

endmodule

### rtl/core/suart_checker.sv
// suart_checker: port-level checks on soft_uart_rx_tx, bound into soft_uart_rx_tx.
// Depends on suart_pkg.
module suart_checker
  import suart_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result item dropped while stalled");

  a_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result item shown straight after reset");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[10:3] == 8'd0)
    else $error("rx_byte not zero without rx_valid");

  a_idle_high: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[0])
    else $error("tx line low while transmitter idle");

endmodule

bind soft_uart_rx_tx suart_checker u_suart_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### tb/sv/testbench.sv
// testbench: self-checking bench for soft_uart_rx_tx, the tick-driven 8N1 UART.
// Streams timer ticks with framed and noisy receive levels against an in-bench model.
// Depends on suart_pkg and the soft_uart_rx_tx RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import suart_pkg::*;

  localparam int unsigned LIMIT = 1_000_000;
  // index beyond the register list, must be ignored
  localparam logic [1:0] CFG_NONE = 2'd3;

  typedef struct packed {
    logic [4:0] pad;
    logic       host_ready;
    logic [7:0] send_byte;
    logic       send_request;
    logic       rx_line;
  } tick_t;

  typedef struct packed {
    logic [4:0] pad;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       tx_idle;
    logic       tx_line;
  } line_out_t;

  typedef enum {RUN_PLAIN, RUN_QUIET, RUN_BACKLOG, RUN_PAUSE} run_style_t;

  class uart_tracker;
    logic       en;
    logic [7:0] bit_ticks;
    logic [7:0] hold_ticks;
    rx_phase_t  rx_ph;
    logic [7:0] rx_el;
    logic [7:0] rx_sh;
    logic [3:0] rx_cnt;
    tx_phase_t  tx_ph;
    logic [7:0] tx_el;
    logic [7:0] tx_dat;
    logic [3:0] tx_cnt;
    logic       tx_lvl;
    line_out_t  due_outputs[$];
    int         mismatches;
    int         checked;
    int         forwarded;
    int         sends;

    function new();
      en = 1'b0;
      bit_ticks = BIT_TICKS_RST;
      hold_ticks = RX_HOLD_RST;
      rx_ph = RX_IDLE;
      rx_el = '0;
      rx_sh = '0;
      rx_cnt = '0;
      tx_ph = TX_IDLE;
      tx_el = '0;
      tx_dat = '0;
      tx_cnt = '0;
      tx_lvl = 1'b1;
      mismatches = 0;
      checked = 0;
      forwarded = 0;
      sends = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CFG_ENABLE: en = val[0];
        CFG_BIT_TICKS: bit_ticks = val;
        CFG_RX_HOLD: hold_ticks = val;
        default: ;
      endcase
    endfunction

    function void take_tick(tick_t t);
      line_out_t r;
      r = '0;
      if (rx_el != ELAPSED_MAX) rx_el++;
      if (tx_el != ELAPSED_MAX) tx_el++;
      if (t.send_request && en) begin
        tx_ph = TX_START;
        tx_dat = t.send_byte;
        tx_el = '0;
        sends++;
      end
      case (rx_ph)
        RX_IDLE: if (!t.rx_line) begin
          rx_el = '0;
          rx_sh = '0;
          rx_cnt = '0;
          rx_ph = RX_DATA;
        end
        RX_DATA: if (rx_el >= bit_ticks) begin
          rx_sh = {t.rx_line, rx_sh[7:1]};
          rx_el = '0;
          rx_cnt = rx_cnt + 4'd1;
          if (rx_cnt >= NUM_BITS) rx_ph = RX_HOLD;
        end
        RX_HOLD: if (rx_el >= hold_ticks) begin
          if (en && t.host_ready) begin
            r.rx_valid = 1'b1;
            r.rx_byte = rx_sh;
            forwarded++;
          end
          rx_ph = RX_IDLE;
        end
        default: rx_ph = RX_IDLE;
      endcase
      case (tx_ph)
        TX_IDLE: begin
          tx_lvl = 1'b1;
          tx_cnt = '0;
        end
        TX_START: if (tx_el >= bit_ticks) begin
          tx_ph = TX_DATA;
          tx_lvl = 1'b0;
          tx_el = '0;
        end
        TX_DATA: if (tx_el >= bit_ticks) begin
          if (tx_cnt > LAST_BIT) begin
            tx_ph = TX_STOP;
          end else begin
            tx_el = '0;
            tx_lvl = tx_dat[tx_cnt[2:0]];
            tx_cnt = tx_cnt + 4'd1;
          end
        end
        default: begin
          tx_el = '0;
          tx_lvl = 1'b1;
          tx_ph = TX_IDLE;
          tx_cnt = '0;
        end
      endcase
      r.tx_line = tx_lvl;
      r.tx_idle = (tx_ph == TX_IDLE);
      due_outputs.push_back(r);
    endfunction

    function void compare_output(logic [15:0] raw);
      line_out_t got;
      line_out_t want;
      got = line_out_t'(raw);
      checked++;
      if (due_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", raw);
        return;
      end
      want = due_outputs.pop_front();
      if (got.tx_line !== want.tx_line || got.tx_idle !== want.tx_idle ||
          got.rx_valid !== want.rx_valid || got.rx_byte !== want.rx_byte ||
          got.pad !== want.pad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("item %0d: expected line %b idle %b valid %b byte %h pad %h, got %b %b %b %h %h",
                   checked, want.tx_line, want.tx_idle, want.rx_valid, want.rx_byte, want.pad,
                   got.tx_line, got.tx_idle, got.rx_valid, got.rx_byte, got.pad);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  uart_tracker tracker = new();
  logic        line_plan[$];
  bit          quiet = 1'b0;
  bit          long_hold = 1'b0;
  int unsigned cycles = 0;
  int          settings = 0;

  soft_uart_rx_tx i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               tracker.due_outputs.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.compare_output(m_tdata);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sink side: random stalls, plus one long hold-off on request
  initial begin
    int left;
    left = 0;
    forever begin
      @(negedge clk);
      if (left > 0) begin
        left--;
      end else if (long_hold) begin
        long_hold = 1'b0;
        left = 150;
      end else if (!quiet && $urandom_range(0, 99) < 20) begin
        left = pick_gap();
      end
      m_tready <= (left == 0);
    end
  end

  task automatic put_tick(input tick_t t);
    int gap;
    gap = quiet ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= t;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.take_tick(t);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (tracker.due_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, val);
  endtask

  task automatic configure(input logic en, input logic [7:0] bt, input logic [7:0] hold);
    wait_drain();
    line_plan.delete();
    settings++;
    write_reg(CFG_ENABLE, {7'($urandom), en});
    write_reg(CFG_BIT_TICKS, bt);
    write_reg(CFG_RX_HOLD, hold);
    write_reg(CFG_NONE, 8'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receive line: mostly whole frames, some cut short, some noise
  function automatic void plan_line();
    int per;
    int kind;
    int nbits;
    logic [7:0] b;
    per = (tracker.bit_ticks == 0) ? 1 : int'(tracker.bit_ticks);
    kind = $urandom_range(0, 9);
    b = 8'($urandom);
    if (kind < 8) begin
      nbits = (kind < 6) ? 8 : $urandom_range(0, 7);
      repeat (per) line_plan.push_back(1'b0);
      for (int k = 0; k < nbits; k++) repeat (per) line_plan.push_back(b[k]);
      repeat (per + int'(tracker.hold_ticks) + $urandom_range(0, 3))
        line_plan.push_back(1'b1);
    end else begin
      repeat ($urandom_range(1, 8)) line_plan.push_back(1'($urandom));
    end
  endfunction

  task automatic run_random(input int n, input run_style_t style);
    tick_t t;
    int per;
    quiet = (style == RUN_QUIET);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2 && style == RUN_BACKLOG) long_hold = 1'b1;
      if (i == n / 2 && style == RUN_PAUSE) wait_drain();
      if (line_plan.size() == 0) plan_line();
      per = (tracker.bit_ticks == 0) ? 1 : int'(tracker.bit_ticks);
      t = '0;
      t.rx_line = line_plan.pop_front();
      t.send_request = (i == 0) || ($urandom_range(0, 10 * per + 8) == 0);
      t.send_byte = 8'($urandom);
      t.host_ready = ($urandom_range(0, 9) != 0);
      put_tick(t);
    end
    quiet = 1'b0;
  endtask

  initial begin
    tick_t t;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // reset settings: transmitter and forwarding gated off
    run_random(30, RUN_PLAIN);

    // zero bit period: one bit per tick; frames 0xFF then 0x00, restart mid-send,
    // second byte refused by the host
    configure(1'b1, 8'd0, 8'd0);
    for (int i = 0; i < 25; i++) begin
      t = '0;
      t.rx_line = !(i == 0 || (i >= 10 && i <= 18));
      t.send_request = (i == 0 || i == 4);
      t.send_byte = (i == 0) ? 8'hFF : 8'h00;
      t.host_ready = (i != 19);
      put_tick(t);
    end

    configure(1'b1, 8'd1, 8'd0);
    run_random(150, RUN_PLAIN);
    configure(1'b1, 8'd2, 8'd3);
    run_random(150, RUN_PAUSE);
    configure(1'b0, 8'd1, 8'd2);
    run_random(100, RUN_PLAIN);
    configure(1'b1, 8'd3, 8'd24);
    run_random(150, RUN_QUIET);
    configure(1'b1, 8'd1, 8'd255);
    run_random(300, RUN_BACKLOG);
    configure(1'b1, 8'd255, 8'd0);
    run_random(200, RUN_PLAIN);
    configure(1'b1, 8'd5, 8'd1);
    run_random(100, RUN_PLAIN);

    wait_drain();
    repeat (8) @(posedge clk);
    $display("%0d tick results checked over %0d register settings", tracker.checked,
             settings);
    $display("%0d received bytes forwarded, %0d send requests taken, %0d mismatches",
             tracker.forwarded, tracker.sends, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.due_outputs.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/core/suart_pkg.sv
rtl/core/soft_uart_rx_tx.sv
rtl/core/suart_checker.sv
tb/sv/testbench.sv
